/* hdl/kfp_pkg.sv */
// Package: shared types and constants of the flux bitcell tracker.
package kfp_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE, S_RUN, S_PB_S, S_PB_W, S_TST_MUL, S_TST, S_GAIN, S_SHIFT,
    S_K_S, S_K_W, S_EXP_MUL, S_MAG, S_CORR_MUL, S_CORR_S, S_CORR_W, S_UPD,
    S_VAR_LO, S_VAR_HI, S_VAR_FIN, S_HWR, S_SUM_RD, S_SUM_ACC, S_MEAN_S,
    S_MEAN_W, S_SPR_RD, S_SPR_MUL, S_SPR_ACC, S_SPR_S, S_SPR_W, S_DONE
  } state_t;

  // Configuration register indexes
  localparam logic [1:0] CFG_INIT_CELL = 2'd0;
  localparam logic [1:0] CFG_INIT_VAR  = 2'd1;
  localparam logic [1:0] CFG_PROC_NSE  = 2'd2;
  localparam logic [1:0] CFG_MEAS_NSE  = 2'd3;

  localparam int HIST_DEPTH  = 16;
  localparam int HIST_AW     = 4;
  localparam int FILL_W      = 5;
  localparam int MAX_RUN     = 5;
  localparam int MIN_FILL    = 4;
  localparam int MIN_CELL_NS = 1500;
  localparam int MAX_CELL_NS = 5000;

  // Shared divider geometry
  localparam int DIV_NW = 53;
  localparam int DIV_DW = 33;

  localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

endpackage

/* hdl/kfp_div.sv */
// Shared restoring divider, one quotient bit per cycle.
module kfp_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [kfp_pkg::DIV_NW-1:0]  dividend,
  input  logic [kfp_pkg::DIV_DW-1:0]  divisor,
  output logic                        done,
  output logic [kfp_pkg::DIV_NW-1:0]  quotient
);

  localparam int CW = $clog2(kfp_pkg::DIV_NW);

  logic                       run_r;
  logic                       done_r;
  logic [CW-1:0]              cnt_r;
  logic [kfp_pkg::DIV_DW-1:0] rem_r;
  logic [kfp_pkg::DIV_DW-1:0] div_r;
  logic [kfp_pkg::DIV_NW-1:0] quo_r;
  logic [kfp_pkg::DIV_DW:0]   trial;
  logic                       fits;

  // Partial remainder with the next dividend bit shifted in
  always_comb begin
    trial = {rem_r, quo_r[kfp_pkg::DIV_NW-1]};
    fits  = (trial >= {1'b0, div_r});
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CW'(kfp_pkg::DIV_NW - 1);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      div_r <= divisor;
      quo_r <= dividend;
    end else if (run_r) begin
      rem_r <= fits ? kfp_pkg::DIV_DW'(trial - {1'b0, div_r})
                    : trial[kfp_pkg::DIV_DW-1:0];
      quo_r <= {quo_r[kfp_pkg::DIV_NW-2:0], fits};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

/* hdl/kalman_flux_pll_top.sv */
// Top level: Kalman bitcell tracker for flux-transition intervals.
// One interval beat is taken at a time; the block stalls its input until the
// item is finished. A beat runs the run search, then one pass of the shared
// 53-step divider for the per-bit time; a rejected outlier ends there. An
// accepted sample adds the gain, correction, mean and spread divisions (up to
// four more divider passes), up to 17 normalizing shifts, and history passes
// over the n stored entries. A finished result waits in the output register
// while the next beat enters.
module kalman_flux_pll_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_flux_interval,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_run_cells,
  output logic        out_rejected,
  output logic [28:0] out_cell_estimate,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [28:0] CELL_LO = 29'(kfp_pkg::MIN_CELL_NS * 65536);
  localparam logic [28:0] CELL_HI = 29'(kfp_pkg::MAX_CELL_NS * 65536);
  localparam int AW = kfp_pkg::HIST_AW;

  function automatic logic [28:0] cell_from_ns(input logic [12:0] ns);
    logic [12:0] c;
    c = ns;
    if (c < 13'(kfp_pkg::MIN_CELL_NS)) c = 13'(kfp_pkg::MIN_CELL_NS);
    if (c > 13'(kfp_pkg::MAX_CELL_NS)) c = 13'(kfp_pkg::MAX_CELL_NS);
    return {c, 16'h0000};
  endfunction

  kfp_pkg::state_t state_r, state_nxt;

  // Filter state and registers
  logic [28:0] cell_est_r;
  logic [47:0] est_var_r;
  logic [23:0] pn_r;
  logic [31:0] mn_r;
  logic [31:0] hist_mean_r;
  logic [47:0] hist_spread_r;
  logic [AW-1:0] wslot_r;
  logic [kfp_pkg::FILL_W-1:0] fill_r;

  // Working registers
  logic [31:0] f_r;
  logic [47:0] p_r;
  logic [2:0]  bc_r;
  logic [2:0]  cnt_r;
  logic [32:0] run_acc_r;
  logic [31:0] pb_r;
  logic        rej_r;
  logic [48:0] s_r;
  logic [47:0] ps_r;
  logic [16:0] k_r;
  logic [31:0] mag_r;
  logic        neg_r;
  logic [32:0] corr_r;
  logic [65:0] prod_r;
  logic [52:0] acc_r;
  logic [35:0] sum_r;
  logic [AW-1:0] idx_r;
  logic [31:0] rd_data_r;
  logic [31:0] hist_mem [kfp_pkg::HIST_DEPTH];

  // Output register
  logic        out_valid_r;
  logic [2:0]  out_run_r;
  logic        out_rej_r;
  logic [28:0] out_cell_r;

  // Shared units
  logic [32:0] mul_a, mul_b;
  logic [65:0] mul_p;
  logic        div_start, div_done;
  logic [kfp_pkg::DIV_NW-1:0] div_n, div_q;
  logic [kfp_pkg::DIV_DW-1:0] div_d;

  // Combinational helpers
  logic        in_acc;
  logic [48:0] p_sum;
  logic [31:0] d_pb, d_rd;
  logic [47:0] var_fl;
  logic [51:0] lim;
  logic        outl;
  logic [66:0] var_tot;
  logic [50:0] var_new;
  logic signed [34:0] nc_s;
  logic [kfp_pkg::FILL_W-1:0] nm1;
  logic        last_idx;
  logic        res_load;

  kfp_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_n),
    .divisor  (div_d),
    .done     (div_done),
    .quotient (div_q)
  );

  assign mul_p = mul_a * mul_b;

  always_comb begin
    in_acc   = in_valid && !in_stall;
    p_sum    = 49'(est_var_r) + 49'(pn_r);
    d_pb     = (pb_r >= hist_mean_r) ? pb_r - hist_mean_r : hist_mean_r - pb_r;
    d_rd     = (rd_data_r >= hist_mean_r) ? rd_data_r - hist_mean_r
                                          : hist_mean_r - rd_data_r;
    var_fl   = (hist_spread_r < 48'h10000) ? 48'h10000 : hist_spread_r;
    lim      = {var_fl, 3'b000} + 52'(var_fl);
    outl     = (fill_r >= kfp_pkg::FILL_W'(kfp_pkg::MIN_FILL)) &&
               (68'(prod_r[63:0]) > {lim, 16'h0000});
    var_tot  = 67'(acc_r) + (67'(prod_r[32:0]) << 32) + 67'(32768);
    var_new  = var_tot[66:16];
    nc_s     = neg_r ? 35'(cell_est_r) - 35'(corr_r) : 35'(cell_est_r) + 35'(corr_r);
    nm1      = fill_r - 1'b1;
    last_idx = (idx_r == nm1[AW-1:0]);
    res_load = (state_r == kfp_pkg::S_DONE) && (!out_valid_r || !out_stall);
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      kfp_pkg::S_IDLE:     if (in_acc) state_nxt = kfp_pkg::S_RUN;
      kfp_pkg::S_RUN:
        if (cnt_r == 3'(kfp_pkg::MAX_RUN - 1)) state_nxt = kfp_pkg::S_PB_S;
      kfp_pkg::S_PB_S:     state_nxt = kfp_pkg::S_PB_W;
      kfp_pkg::S_PB_W:     if (div_done) state_nxt = kfp_pkg::S_TST_MUL;
      kfp_pkg::S_TST_MUL:  state_nxt = kfp_pkg::S_TST;
      kfp_pkg::S_TST:      state_nxt = outl ? kfp_pkg::S_DONE : kfp_pkg::S_GAIN;
      kfp_pkg::S_GAIN:     state_nxt = kfp_pkg::S_SHIFT;
      kfp_pkg::S_SHIFT: begin
        if (s_r[48:32] != '0)  state_nxt = kfp_pkg::S_SHIFT;
        else if (s_r == '0)    state_nxt = kfp_pkg::S_EXP_MUL;
        else                   state_nxt = kfp_pkg::S_K_S;
      end
      kfp_pkg::S_K_S:      state_nxt = kfp_pkg::S_K_W;
      kfp_pkg::S_K_W:      if (div_done) state_nxt = kfp_pkg::S_EXP_MUL;
      kfp_pkg::S_EXP_MUL:  state_nxt = kfp_pkg::S_MAG;
      kfp_pkg::S_MAG:      state_nxt = kfp_pkg::S_CORR_MUL;
      kfp_pkg::S_CORR_MUL: state_nxt = kfp_pkg::S_CORR_S;
      kfp_pkg::S_CORR_S:   state_nxt = kfp_pkg::S_CORR_W;
      kfp_pkg::S_CORR_W:   if (div_done) state_nxt = kfp_pkg::S_UPD;
      kfp_pkg::S_UPD:      state_nxt = kfp_pkg::S_VAR_LO;
      kfp_pkg::S_VAR_LO:   state_nxt = kfp_pkg::S_VAR_HI;
      kfp_pkg::S_VAR_HI:   state_nxt = kfp_pkg::S_VAR_FIN;
      kfp_pkg::S_VAR_FIN:  state_nxt = kfp_pkg::S_HWR;
      kfp_pkg::S_HWR:      state_nxt = kfp_pkg::S_SUM_RD;
      kfp_pkg::S_SUM_RD:   state_nxt = kfp_pkg::S_SUM_ACC;
      kfp_pkg::S_SUM_ACC:  state_nxt = last_idx ? kfp_pkg::S_MEAN_S : kfp_pkg::S_SUM_RD;
      kfp_pkg::S_MEAN_S:   state_nxt = kfp_pkg::S_MEAN_W;
      kfp_pkg::S_MEAN_W:
        if (div_done) state_nxt = (fill_r > 5'd1) ? kfp_pkg::S_SPR_RD : kfp_pkg::S_DONE;
      kfp_pkg::S_SPR_RD:   state_nxt = kfp_pkg::S_SPR_MUL;
      kfp_pkg::S_SPR_MUL:  state_nxt = kfp_pkg::S_SPR_ACC;
      kfp_pkg::S_SPR_ACC:  state_nxt = last_idx ? kfp_pkg::S_SPR_S : kfp_pkg::S_SPR_RD;
      kfp_pkg::S_SPR_S:    state_nxt = kfp_pkg::S_SPR_W;
      kfp_pkg::S_SPR_W:    if (div_done) state_nxt = kfp_pkg::S_DONE;
      kfp_pkg::S_DONE:     if (res_load) state_nxt = kfp_pkg::S_IDLE;
      default:             state_nxt = kfp_pkg::S_IDLE;
    endcase
  end

  // Shared unit operand selection
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_n     = '0;
    div_d     = '0;
    unique case (state_r)
      kfp_pkg::S_PB_S: begin
        div_start = 1'b1;
        div_n     = 53'(f_r) + 53'(bc_r >> 1);
        div_d     = 33'(bc_r);
      end
      kfp_pkg::S_TST_MUL: begin
        mul_a = 33'(d_pb);
        mul_b = 33'(d_pb);
      end
      kfp_pkg::S_K_S: begin
        div_start = 1'b1;
        div_n     = 53'({ps_r[31:0], 16'h0000}) + 53'(s_r[32:1]);
        div_d     = s_r[32:0];
      end
      kfp_pkg::S_EXP_MUL: begin
        mul_a = 33'(cell_est_r);
        mul_b = 33'(bc_r);
      end
      kfp_pkg::S_CORR_MUL: begin
        mul_a = 33'(mag_r);
        mul_b = 33'(k_r);
      end
      kfp_pkg::S_CORR_S: begin
        div_start = 1'b1;
        div_n     = 53'(prod_r[48:0]) + 53'({bc_r, 15'h0000});
        div_d     = 33'({bc_r, 16'h0000});
      end
      kfp_pkg::S_VAR_LO: begin
        mul_a = 33'(p_r[31:0]);
        mul_b = 33'(17'h10000 - k_r);
      end
      kfp_pkg::S_VAR_HI: begin
        mul_a = 33'(p_r[47:32]);
        mul_b = 33'(17'h10000 - k_r);
      end
      kfp_pkg::S_MEAN_S: begin
        div_start = 1'b1;
        div_n     = 53'(sum_r) + 53'(fill_r >> 1);
        div_d     = 33'(fill_r);
      end
      kfp_pkg::S_SPR_MUL: begin
        mul_a = 33'(d_rd);
        mul_b = 33'(d_rd);
      end
      kfp_pkg::S_SPR_S: begin
        div_start = 1'b1;
        div_n     = acc_r + 53'(nm1 >> 1);
        div_d     = 33'(nm1);
      end
      default: begin
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= kfp_pkg::S_IDLE;
    else        state_r <= state_nxt;
  end

  // Filter state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_est_r    <= cell_from_ns(13'd2000);
      est_var_r     <= 48'd13107200;
      pn_r          <= 24'd13107;
      mn_r          <= 32'd6553600;
      hist_mean_r   <= 32'(cell_from_ns(13'd2000));
      hist_spread_r <= '0;
      wslot_r       <= '0;
      fill_r        <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          kfp_pkg::CFG_INIT_CELL: begin
            cell_est_r  <= cell_from_ns(cfg_data[12:0]);
            hist_mean_r <= 32'(cell_from_ns(cfg_data[12:0]));
          end
          kfp_pkg::CFG_INIT_VAR: est_var_r <= 48'(cfg_data);
          kfp_pkg::CFG_PROC_NSE: pn_r      <= cfg_data[23:0];
          kfp_pkg::CFG_MEAS_NSE: mn_r      <= cfg_data;
          default: begin
          end
        endcase
      end
      // estimate update with clamp
      if (state_r == kfp_pkg::S_UPD) begin
        if (nc_s < $signed(35'(CELL_LO)))      cell_est_r <= CELL_LO;
        else if (nc_s > $signed(35'(CELL_HI))) cell_est_r <= CELL_HI;
        else                                   cell_est_r <= nc_s[28:0];
      end
      // variance with floor
      if (state_r == kfp_pkg::S_VAR_FIN) begin
        if (var_new < 51'(pn_r)) est_var_r <= 48'(pn_r);
        else                     est_var_r <= var_new[47:0];
      end
      if (state_r == kfp_pkg::S_HWR) begin
        wslot_r <= wslot_r + 1'b1;
        if (fill_r < kfp_pkg::FILL_W'(kfp_pkg::HIST_DEPTH)) fill_r <= fill_r + 1'b1;
      end
      if (state_r == kfp_pkg::S_MEAN_W && div_done) hist_mean_r <= div_q[31:0];
      if (state_r == kfp_pkg::S_SPR_W && div_done)
        hist_spread_r <= (div_q > 53'(kfp_pkg::MASK48)) ? kfp_pkg::MASK48 : div_q[47:0];
      // output beat
      if (res_load)               out_valid_r <= 1'b1;
      else if (!out_stall)        out_valid_r <= 1'b0;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      out_run_r  <= bc_r;
      out_rej_r  <= rej_r;
      out_cell_r <= cell_est_r;
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_r       <= {in_flux_interval, 16'h0000};
      p_r       <= (p_sum[48]) ? kfp_pkg::MASK48 : p_sum[47:0];
      bc_r      <= 3'd1;
      cnt_r     <= '0;
      run_acc_r <= 33'(cell_est_r);
      rej_r     <= 1'b0;
    end
    unique case (state_r)
      kfp_pkg::S_RUN: begin
        // run is the count of odd half-cell marks at or below the interval, at least one
        if ({f_r, 1'b0} >= run_acc_r) bc_r <= cnt_r + 1'b1;
        run_acc_r <= run_acc_r + {3'b000, cell_est_r, 1'b0};
        cnt_r     <= cnt_r + 1'b1;
      end
      kfp_pkg::S_PB_W:     if (div_done) pb_r <= div_q[31:0];
      kfp_pkg::S_TST_MUL:  prod_r <= mul_p;
      kfp_pkg::S_TST:      rej_r <= outl;
      kfp_pkg::S_GAIN: begin
        s_r  <= 49'(p_r) + 49'(mn_r);
        ps_r <= p_r;
        k_r  <= '0;
      end
      kfp_pkg::S_SHIFT: begin
        if (s_r[48:32] != '0) begin
          s_r  <= s_r >> 1;
          ps_r <= ps_r >> 1;
        end
      end
      kfp_pkg::S_K_W:
        if (div_done) k_r <= (div_q > 53'h10000) ? 17'h10000 : div_q[16:0];
      kfp_pkg::S_EXP_MUL:  prod_r <= mul_p;
      kfp_pkg::S_MAG: begin
        neg_r <= (f_r < prod_r[31:0]);
        mag_r <= (f_r < prod_r[31:0]) ? prod_r[31:0] - f_r : f_r - prod_r[31:0];
      end
      kfp_pkg::S_CORR_MUL: prod_r <= mul_p;
      kfp_pkg::S_CORR_W:   if (div_done) corr_r <= div_q[32:0];
      kfp_pkg::S_VAR_LO:   prod_r <= mul_p;
      kfp_pkg::S_VAR_HI: begin
        acc_r  <= prod_r[52:0];
        prod_r <= mul_p;
      end
      kfp_pkg::S_HWR: begin
        idx_r <= '0;
        sum_r <= '0;
      end
      kfp_pkg::S_SUM_ACC: begin
        sum_r <= sum_r + 36'(rd_data_r);
        idx_r <= idx_r + 1'b1;
      end
      kfp_pkg::S_MEAN_W: begin
        idx_r <= '0;
        acc_r <= '0;
      end
      kfp_pkg::S_SPR_MUL:  prod_r <= mul_p;
      kfp_pkg::S_SPR_ACC: begin
        acc_r <= acc_r + 53'(prod_r[63:16]);
        idx_r <= idx_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

  // History memory, registered read
  always_ff @(posedge clk) begin
    if (state_r == kfp_pkg::S_HWR) hist_mem[wslot_r] <= pb_r;
    rd_data_r <= hist_mem[idx_r];
  end

  assign in_stall          = (state_r != kfp_pkg::S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_run_cells     = out_run_r;
  assign out_rejected      = out_rej_r;
  assign out_cell_estimate = out_cell_r;

endmodule

/* hdl/kfp_chk.sv */
// Port-level checker for the flux bitcell tracker, bound to the top level.
module kfp_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [15:0] in_flux_interval,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_run_cells,
  input logic        out_rejected,
  input logic [28:0] out_cell_estimate,
  input logic        cfg_we,
  input logic [1:0]  cfg_index,
  input logic [31:0] cfg_data
);

  // a held result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // one item at a time: after a beat is taken the input stalls
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // run length is always in range
  a_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_run_cells != 3'd0) && (out_run_cells <= 3'd5))
    else $error("run length out of range");

  // estimate stays inside the clamp window
  a_est: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_cell_estimate >= 29'd98304000) &&
                  (out_cell_estimate <= 29'd327680000))
    else $error("cell estimate outside clamp window");

endmodule

bind kalman_flux_pll_top kfp_chk u_kfp_chk (.*);
